### rtl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_PAD_COMP,
		ST_LEN,
		ST_FIN_COMP,
		ST_FIN_WAIT
	} hs_state_t;

	// Phases of the compression engine.
	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_RUN,
		ENG_ADD
	} eng_phase_t;

	// Commands from the sequencer to the engine.
	typedef struct packed {
		logic       shift;
		logic [7:0] din;
		logic       start;
		logic       init;
	} eng_cmd_t;

	// Engine status back to the sequencer.
	typedef struct packed {
		logic done;
	} eng_stat_t;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

### rtl/shs_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_engine
// Block window, message schedule, one shared round unit and chaining hash.
// ----------------------------------------------------------------------------
module shs_engine
	import shs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire eng_cmd_t     cmd,
	output eng_stat_t         stat,
	output logic [255:0]      hash
);

	// The window holds the 64-byte block; its top word is the current W.
	logic [511:0] win_q;
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic [5:0]   round_q;
	eng_phase_t   phase_q, phase_d;

	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2, ch, maj;

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[round_q] + w0;
	assign t2  = bsig0(v_q[0]) + maj;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			ENG_IDLE: begin
				if (cmd.start) phase_d = ENG_RUN;
			end
			ENG_RUN: begin
				if (round_q == LAST_ROUND) phase_d = ENG_ADD;
			end
			ENG_ADD: begin
				phase_d = ENG_IDLE;
			end
			default: phase_d = ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ENG_IDLE;
			round_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (cmd.start) round_q <= '0;
			else if (phase_q == ENG_RUN) round_q <= round_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= HASH_IV[i];
		end else if (cmd.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= HASH_IV[i];
		end else if (phase_q == ENG_ADD) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			win_q <= {win_q[503:0], cmd.din};
		end else if (phase_q == ENG_RUN) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (phase_q == ENG_RUN) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign stat.done = (phase_q == ENG_ADD);
	assign hash = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule
`default_nettype wire

### rtl/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream with padding and digest output.
// ----------------------------------------------------------------------------
// Usage:
// The slave side takes one item per handshake: tuser low absorbs the byte in
// tdata, tuser high finishes the message. An absorb item that does not fill
// the 64-byte block leaves tready high. The item that fills it starts the
// shared round unit, which runs 64 rounds at one per cycle followed by the
// chaining update, so tready stays low until that update is done.
// A finish item pads the block one byte per cycle while no compression runs
// (up to 63 zero bytes, a step to turn to the length and eight length bytes),
// runs one or two compressions, then hands the eight digest words to the
// output register and restarts from the initial hash values.
// The master side gives the words in order, index 0 first, tlast on the
// eighth. A stalled receiver holds the words; absorb items are still taken
// meanwhile, and only a following finish waits for the output to drain.
// Reset clears the hash to its initial values, the block position, the bit
// count and the output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
	import shs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic             m_axis_tlast
);

	hs_state_t    state_q, state_d;
	logic [5:0]   fill_q, fill_d;
	logic [54:0]  blocks_q, blocks_d;
	logic [63:0]  len_q, len_d;
	logic [255:0] digest_q;
	logic [2:0]   idx_q;
	logic         out_valid_q;
	logic         load_out;
	logic         in_acc, out_acc;
	eng_cmd_t     cmd;
	eng_stat_t    stat;
	logic [255:0] hash;

	shs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.hash   (hash)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		blocks_d = blocks_q;
		len_d    = len_q;
		load_out = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.shift = 1'b1;
					fill_d = fill_q + 6'd1;
					if (!s_axis_tuser) begin
						cmd.din = s_axis_tdata;
						if (fill_q == LAST_POS) begin
							cmd.start = 1'b1;
							blocks_d = blocks_q + 55'd1;
							state_d = ST_COMP;
						end
					end else begin
						// Completed blocks are whole multiples of 512 bits.
						cmd.din = PAD_BYTE;
						len_d = {blocks_q, fill_q, 3'b000};
						if (fill_q == LAST_POS) begin
							cmd.start = 1'b1;
							state_d = ST_PAD_COMP;
						end else begin
							state_d = ST_PAD;
						end
					end
				end
			end
			ST_COMP: begin
				if (stat.done) state_d = ST_IDLE;
			end
			ST_PAD: begin
				if (fill_q == LEN_START) begin
					state_d = ST_LEN;
				end else begin
					cmd.shift = 1'b1;
					fill_d = fill_q + 6'd1;
					if (fill_q == LAST_POS) begin
						cmd.start = 1'b1;
						state_d = ST_PAD_COMP;
					end
				end
			end
			ST_PAD_COMP: begin
				if (stat.done) state_d = ST_PAD;
			end
			ST_LEN: begin
				cmd.shift = 1'b1;
				cmd.din = len_q[63:56];
				len_d = {len_q[55:0], 8'h00};
				fill_d = fill_q + 6'd1;
				if (fill_q == LAST_POS) begin
					cmd.start = 1'b1;
					state_d = ST_FIN_COMP;
				end
			end
			ST_FIN_COMP: begin
				if (stat.done) state_d = ST_FIN_WAIT;
			end
			ST_FIN_WAIT: begin
				if (!out_valid_q) begin
					load_out = 1'b1;
					cmd.init = 1'b1;
					blocks_d = '0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			blocks_q    <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			blocks_q <= blocks_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (out_acc) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		if (load_out) begin
			digest_q <= hash;
		end else if (out_acc) begin
			digest_q <= {digest_q[223:0], 32'h0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, idx_q, digest_q[255:224]};
	assign m_axis_tlast  = (idx_q == 3'd7);

endmodule
`default_nettype wire
